>>> hw/rtl/cpst_pkg.sv
// Package for the charge port status tracker.
// Holds the configuration struct, register indexes, status codes and the state encoding.
// No dependencies.
`default_nettype none

package cpst_pkg;

   // Width of the configuration address bus (six 32-bit registers at 4*i).
   localparam int ADDR_W = 5;
   localparam int REG_IDX_W = 3;
   localparam int CFG_W = 16;

   localparam logic [REG_IDX_W-1:0] REG_ATTACH_DEBOUNCE = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_DETACH_DEBOUNCE = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_STARTUP_SETTLE  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_CHARGING_ON_MA  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_DONE_MAX_MA     = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_DONE_DWELL      = 3'd5;

   localparam logic [1:0] STATUS_OFF      = 2'd0;
   localparam logic [1:0] STATUS_STARTING = 2'd1;
   localparam logic [1:0] STATUS_CHARGING = 2'd2;
   localparam logic [1:0] STATUS_DONE     = 2'd3;

   typedef enum logic [3:0] {
      PORT_OFF      = 4'b0001,
      PORT_STARTING = 4'b0010,
      PORT_CHARGING = 4'b0100,
      PORT_DONE     = 4'b1000
   } port_state_type;

   typedef struct packed {
      logic [CFG_W-1:0] attach_debounce;
      logic [CFG_W-1:0] detach_debounce;
      logic [CFG_W-1:0] startup_settle;
      logic [CFG_W-1:0] charging_on_ma;
      logic [CFG_W-1:0] done_max_ma;
      logic [CFG_W-1:0] done_dwell;
   } cfg_type;

   typedef struct packed {
      logic [1:0] status;
      logic       red;
      logic       green;
   } result_type;

endpackage

`default_nettype wire

>>> hw/rtl/cpst_regs.sv
// Configuration register file with an APB-style slave port.
// Depends on cpst_pkg for the register indexes and the configuration struct.
`default_nettype none

module cpst_regs (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [cpst_pkg::ADDR_W-1:0] paddr,
   input  wire logic [31:0]                 pwdata,
   output      logic [31:0]                 prdata,
   output      logic                        pready,
   output      cpst_pkg::cfg_type           cfg
);

   cpst_pkg::cfg_type cfg_ff, cfg_in;
   logic [cpst_pkg::REG_IDX_W-1:0] index;
   logic [cpst_pkg::CFG_W-1:0] value;
   logic [cpst_pkg::CFG_W-1:0] read_value;
   logic write_en;

   assign index    = paddr[cpst_pkg::ADDR_W-1:2];
   assign value    = pwdata[cpst_pkg::CFG_W-1:0];
   assign pready   = 1'b1;
   assign write_en = psel & penable & pwrite & pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            cpst_pkg::REG_ATTACH_DEBOUNCE: cfg_in.attach_debounce = value;
            cpst_pkg::REG_DETACH_DEBOUNCE: cfg_in.detach_debounce = value;
            cpst_pkg::REG_STARTUP_SETTLE:  cfg_in.startup_settle  = value;
            cpst_pkg::REG_CHARGING_ON_MA:  cfg_in.charging_on_ma  = value;
            cpst_pkg::REG_DONE_MAX_MA:     cfg_in.done_max_ma     = value;
            cpst_pkg::REG_DONE_DWELL:      cfg_in.done_dwell      = value;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attach_debounce <= 16'd4;
         cfg_ff.detach_debounce <= 16'd4;
         cfg_ff.startup_settle  <= 16'd10;
         cfg_ff.charging_on_ma  <= 16'd100;
         cfg_ff.done_max_ma     <= 16'd50;
         cfg_ff.done_dwell      <= 16'd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (index)
         cpst_pkg::REG_ATTACH_DEBOUNCE: read_value = cfg_ff.attach_debounce;
         cpst_pkg::REG_DETACH_DEBOUNCE: read_value = cfg_ff.detach_debounce;
         cpst_pkg::REG_STARTUP_SETTLE:  read_value = cfg_ff.startup_settle;
         cpst_pkg::REG_CHARGING_ON_MA:  read_value = cfg_ff.charging_on_ma;
         cpst_pkg::REG_DONE_MAX_MA:     read_value = cfg_ff.done_max_ma;
         cpst_pkg::REG_DONE_DWELL:      read_value = cfg_ff.done_dwell;
         default:                       read_value = '0;
      endcase
   end

   assign prdata = {{(32 - cpst_pkg::CFG_W){1'b0}}, read_value};
   assign cfg    = cfg_ff;

endmodule

`default_nettype wire

>>> hw/rtl/cpst_core.sv
// Status update logic: debounce, settle and dwell counters plus the port state machine.
// Depends on cpst_pkg for the configuration struct, state encoding and status codes.
`default_nettype none

module cpst_core #(
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire logic                    attached,
   input  wire logic [15:0]             port_current,
   input  wire cpst_pkg::cfg_type       cfg,
   output      cpst_pkg::result_type    result
);

   localparam int CMP_W = (COUNT_WIDTH > cpst_pkg::CFG_W) ? COUNT_WIDTH : cpst_pkg::CFG_W;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

   cpst_pkg::port_state_type state_ff, state_in;
   logic [COUNT_WIDTH-1:0] attach_count_ff, attach_count_in;
   logic [COUNT_WIDTH-1:0] detach_count_ff, detach_count_in;
   logic [COUNT_WIDTH-1:0] settle_count_ff, settle_count_in;
   logic [COUNT_WIDTH-1:0] dwell_count_ff, dwell_count_in;
   logic [COUNT_WIDTH-1:0] attach_next, detach_next, dwell_next;
   logic [CMP_W-1:0] settle_wide;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
      sat_inc = (v == CNT_MAX) ? v : v + COUNT_WIDTH'(1);
   endfunction

   always_comb begin
      attach_next = attached ? sat_inc(attach_count_ff) : '0;
      detach_next = attached ? '0 : sat_inc(detach_count_ff);
      dwell_next  = sat_inc(dwell_count_ff);
      settle_wide = CMP_W'(cfg.startup_settle);

      state_in        = state_ff;
      attach_count_in = attach_next;
      detach_count_in = detach_next;
      settle_count_in = settle_count_ff;
      dwell_count_in  = dwell_count_ff;

      if (CMP_W'(detach_next) >= CMP_W'(cfg.detach_debounce)) begin
         // Debounced detach: the whole tracker returns to its reset state.
         state_in        = cpst_pkg::PORT_OFF;
         attach_count_in = '0;
         detach_count_in = '0;
         settle_count_in = '0;
         dwell_count_in  = '0;
      end else if (state_ff == cpst_pkg::PORT_OFF) begin
         if (CMP_W'(attach_next) >= CMP_W'(cfg.attach_debounce)) begin
            state_in = cpst_pkg::PORT_STARTING;
            settle_count_in = (settle_wide > CMP_W'(CNT_MAX)) ? CNT_MAX
                                                              : COUNT_WIDTH'(settle_wide);
         end
      end else if (settle_count_ff != '0) begin
         settle_count_in = settle_count_ff - COUNT_WIDTH'(1);
      end else if (port_current >= cfg.charging_on_ma) begin
         state_in       = cpst_pkg::PORT_CHARGING;
         dwell_count_in = '0;
      end else if (port_current <= cfg.done_max_ma) begin
         dwell_count_in = dwell_next;
         if (CMP_W'(dwell_next) >= CMP_W'(cfg.done_dwell)) begin
            state_in = cpst_pkg::PORT_DONE;
         end else if (state_ff == cpst_pkg::PORT_STARTING) begin
            state_in = cpst_pkg::PORT_CHARGING;
         end
      end else begin
         dwell_count_in = '0;
         if (state_ff == cpst_pkg::PORT_STARTING) begin
            state_in = cpst_pkg::PORT_CHARGING;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= cpst_pkg::PORT_OFF;
         attach_count_ff <= '0;
         detach_count_ff <= '0;
         settle_count_ff <= '0;
         dwell_count_ff  <= '0;
      end else if (step) begin
         state_ff        <= state_in;
         attach_count_ff <= attach_count_in;
         detach_count_ff <= detach_count_in;
         settle_count_ff <= settle_count_in;
         dwell_count_ff  <= dwell_count_in;
      end
   end

   // Result of the sample now being processed, taken from the updated state.
   always_comb begin
      unique case (state_in)
         cpst_pkg::PORT_OFF: begin
            result.status = cpst_pkg::STATUS_OFF;
            result.red    = 1'b0;
            result.green  = 1'b0;
         end
         cpst_pkg::PORT_STARTING: begin
            result.status = cpst_pkg::STATUS_STARTING;
            result.red    = 1'b1;
            result.green  = 1'b0;
         end
         cpst_pkg::PORT_CHARGING: begin
            result.status = cpst_pkg::STATUS_CHARGING;
            result.red    = 1'b1;
            result.green  = 1'b0;
         end
         cpst_pkg::PORT_DONE: begin
            result.status = cpst_pkg::STATUS_DONE;
            result.red    = 1'b0;
            result.green  = 1'b1;
         end
         default: begin
            result.status = cpst_pkg::STATUS_OFF;
            result.red    = 1'b0;
            result.green  = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> hw/rtl/charge_port_status_tracker.sv
// Charge port status tracker, top level: input register, status update, result register.
// A sample is captured in the input register and, when it advances, its result is
// captured in the result register, from which the result transfer completes.
// Throughput: one sample per cycle; a stalled result holds the input stage as well.
// Reset (synchronous, active high) clears both pipeline stages, the status state and all
// counters, and loads the configuration registers with their defaults.
`default_nettype none

module charge_port_status_tracker #(
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,

   // Sample channel.
   input  wire logic                        req_tvalid,
   output      logic                        req_tready,
   // tdata fields from bit 0 up: attached [0], port current [16:1], zero padding [23:17].
   input  wire logic [23:0]                 req_tdata,

   // Result channel.
   output      logic                        rsp_tvalid,
   input  wire logic                        rsp_tready,
   // tdata fields from bit 0 up: status [1:0], red [2], green [3], zero padding [7:4].
   output      logic [7:0]                  rsp_tdata,

   // Configuration port.
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [cpst_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                 csr_pwdata,
   output      logic [31:0]                 csr_prdata,
   output      logic                        csr_pready
);

   cpst_pkg::cfg_type    cfg;
   cpst_pkg::result_type result;

   // Input stage: holds one sample until the state update can consume it.
   logic        in_valid_ff, in_valid_in;
   logic        in_attached_ff;
   logic [15:0] in_current_ff;

   // Result stage: holds one finished result until the downstream side takes it.
   logic                 out_valid_ff, out_valid_in;
   cpst_pkg::result_type out_result_ff;

   logic advance;
   logic accept;

   // The sample in the input stage moves on whenever the result stage is empty or is
   // being emptied in this cycle. The state registers update on that same edge, so the
   // next sample always sees the state left by the one before it.
   assign advance    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;
   assign accept     = req_tvalid & req_tready;

   assign in_valid_in  = accept | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_attached_ff <= req_tdata[0];
         in_current_ff  <= req_tdata[16:1];
      end
      if (advance) begin
         out_result_ff <= result;
      end
   end

   cpst_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   cpst_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .attached     (in_attached_ff),
      .port_current (in_current_ff),
      .cfg          (cfg),
      .result       (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_result_ff.green, out_result_ff.red, out_result_ff.status};

endmodule

`default_nettype wire
